### rtl/trajnq_pkg.sv
// Package for the trajectory nearest-point query block.
// Holds the item, configuration and point types and the opcode, status and
// register index codes. Depends on nothing.
package trajnq_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 47;
  localparam int unsigned MatchIdxW = 8;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_APPEND   = 3'd1;
  localparam logic [2:0] OP_POSITION = 3'd2;
  localparam logic [2:0] OP_REL_TIME = 3'd3;
  localparam logic [2:0] OP_ABS_TIME = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_HEADER_TIME  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FORWARD_ONLY = 2'd1;

  localparam logic signed [47:0] T48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] T48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [31:0] point_time;
    logic signed [47:0] query_time;
  } item_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [MatchIdxW-1:0] match_index;
    logic signed [23:0]   match_x;
    logic signed [23:0]   match_y;
    logic signed [31:0]   match_time;
  } item_out_t;

  typedef struct packed {
    logic [CfgDataW-1:0] header_time;
    logic                forward_only;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [31:0] t;
  } point_t;

endpackage

### rtl/trajnq_mem.sv
// Point store of the trajectory query block: one write port, one read port
// with registered read data. Depends on trajnq_pkg for the point type.
module trajnq_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  trajnq_pkg::point_t  wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output trajnq_pkg::point_t  rdata_o
);

  trajnq_pkg::point_t mem_q [Depth];
  trajnq_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/trajnq_engine.sv
// Sequencer of the trajectory query block: clear and append, the scan over
// the point store for position and time queries, and the final point fetch.
// Depends on trajnq_pkg; drives the ports of trajnq_mem.
module trajnq_engine #(
  parameter int unsigned MaxPoints = 256,
  parameter int unsigned AddrW     = 8,
  parameter int unsigned CountW    = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trajnq_pkg::cfg_t      cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  trajnq_pkg::item_in_t  in_item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output trajnq_pkg::item_out_t res_item_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output trajnq_pkg::point_t    mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  trajnq_pkg::point_t    mem_rdata_i
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_DRAIN = 8'b0000_1000,
    ST_PICK  = 8'b0001_0000,
    ST_FETCH = 8'b0010_0000,
    ST_LOAD  = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   issue_q, issue_d;
  logic                v1_q, v2_q, v3_q;
  logic                found_q, found_d;

  logic [2:0]          op_q;
  logic signed [23:0]  qx_q, qy_q;
  logic signed [47:0]  qt_q, tq_q;
  logic [AddrW-1:0]    idx1_q, idx2_q, idx3_q;
  logic [24:0]         ax_q, ay_q;
  logic [49:0]         sqx_q, sqy_q;
  logic [50:0]         dmin_q;
  logic [AddrW-1:0]    best_q, lo_q, sel_q, sel_d;
  logic signed [31:0]  prev_q;
  logic signed [48:0]  dn_q, dp_q;
  trajnq_pkg::item_out_t res_q;

  logic                in_acc, full, is_query, hit;
  logic signed [48:0]  abs_diff;
  logic signed [47:0]  abs_sat;
  logic signed [24:0]  dx, dy;
  logic [50:0]         dsum;
  logic signed [47:0]  rd_time48;
  logic [1:0]          acc_status;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign full        = (count_q == CountW'(MaxPoints));
  assign is_query    = (in_item_i.opcode == trajnq_pkg::OP_POSITION) ||
                       (in_item_i.opcode == trajnq_pkg::OP_REL_TIME) ||
                       (in_item_i.opcode == trajnq_pkg::OP_ABS_TIME);

  assign mem_we_o    = in_acc && (in_item_i.opcode == trajnq_pkg::OP_APPEND) && !full;
  assign mem_waddr_o = count_q[AddrW-1:0];
  assign mem_wdata_o = '{x: in_item_i.coord_x, y: in_item_i.coord_y, t: in_item_i.point_time};
  assign mem_raddr_o = (state_q == ST_SCAN) ? issue_q[AddrW-1:0] : sel_q;

  assign abs_diff  = {qt_q[47], qt_q} - {2'b00, cfg_i.header_time};
  assign abs_sat   = (abs_diff[48] != abs_diff[47]) ?
                     (abs_diff[48] ? trajnq_pkg::T48_MIN : trajnq_pkg::T48_MAX) :
                     abs_diff[47:0];

  assign rd_time48 = {{16{mem_rdata_i.t[31]}}, mem_rdata_i.t};
  assign hit       = !(rd_time48 < tq_q);
  assign dx        = {mem_rdata_i.x[23], mem_rdata_i.x} - {qx_q[23], qx_q};
  assign dy        = {mem_rdata_i.y[23], mem_rdata_i.y} - {qy_q[23], qy_q};
  assign dsum      = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    acc_status = trajnq_pkg::STATUS_OK;
    if ((in_item_i.opcode == trajnq_pkg::OP_APPEND) && full) begin
      acc_status = trajnq_pkg::STATUS_FULL;
    end else if (is_query && (count_q == '0)) begin
      acc_status = trajnq_pkg::STATUS_EMPTY;
    end
  end

  always_comb begin
    if (op_q == trajnq_pkg::OP_POSITION) begin
      sel_d = best_q;
    end else if (!found_q) begin
      sel_d = AddrW'(count_q - CountW'(1));
    end else if (lo_q == '0) begin
      sel_d = '0;
    end else if (cfg_i.forward_only) begin
      sel_d = lo_q;
    end else if (dn_q < dp_q) begin
      sel_d = lo_q;
    end else begin
      sel_d = lo_q - AddrW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    issue_d = issue_q;
    found_d = found_q;
    if (v1_q && !found_q && hit) begin
      found_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          issue_d = '0;
          state_d = ST_RESP;
          unique case (in_item_i.opcode) inside
            trajnq_pkg::OP_CLEAR: count_d = '0;
            trajnq_pkg::OP_APPEND: begin
              if (!full) begin
                count_d = count_q + CountW'(1);
              end
            end
            trajnq_pkg::OP_POSITION, trajnq_pkg::OP_REL_TIME,
            trajnq_pkg::OP_ABS_TIME: begin
              if (count_q != '0) begin
                state_d = ST_PREP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_PREP: begin
        found_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        issue_d = issue_q + CountW'(1);
        if (issue_q == count_q - CountW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v1_q || v2_q || v3_q)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK:  state_d = ST_FETCH;
      ST_FETCH: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      issue_q <= '0;
      found_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      found_q <= found_d;
      v1_q    <= (state_q == ST_SCAN);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_item_i.opcode;
      qx_q  <= in_item_i.coord_x;
      qy_q  <= in_item_i.coord_y;
      qt_q  <= in_item_i.query_time;
      res_q <= '{status: acc_status, match_index: '0, match_x: '0, match_y: '0,
                 match_time: '0};
    end
    if (state_q == ST_PREP) begin
      tq_q <= (op_q == trajnq_pkg::OP_ABS_TIME) ? abs_sat : qt_q;
    end
    idx1_q <= issue_q[AddrW-1:0];
    if (v1_q) begin
      ax_q   <= dx[24] ? 25'(-dx) : 25'(dx);
      ay_q   <= dy[24] ? 25'(-dy) : 25'(dy);
      prev_q <= mem_rdata_i.t;
      if (!found_q && hit) begin
        lo_q <= idx1_q;
        dn_q <= {rd_time48[47], rd_time48} - {tq_q[47], tq_q};
        dp_q <= {tq_q[47], tq_q} - {{17{prev_q[31]}}, prev_q};
      end
    end
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    sqx_q  <= ax_q * ax_q;
    sqy_q  <= ay_q * ay_q;
    if (v3_q && ((idx3_q == '0) || (dsum < dmin_q))) begin
      dmin_q <= dsum;
      best_q <= idx3_q;
    end
    if (state_q == ST_PICK) begin
      sel_q <= sel_d;
    end
    if (state_q == ST_LOAD) begin
      res_q.match_index <= trajnq_pkg::MatchIdxW'(sel_q);
      res_q.match_x     <= mem_rdata_i.x;
      res_q.match_y     <= mem_rdata_i.y;
      res_q.match_time  <= mem_rdata_i.t;
    end
  end

  assign res_valid_o = (state_q == ST_RESP);
  assign res_item_o  = res_q;

  a_full_append_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.opcode == trajnq_pkg::OP_APPEND) && full |=>
    count_q == $past(count_q))
    else $error("append on a full table changed the point count");

  a_pipe_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
    else $error("scan pipeline active outside a scan");

  a_fetch_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (CountW'(sel_q) < count_q))
    else $error("selected point lies beyond the table");

  a_error_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_q.status != trajnq_pkg::STATUS_OK) |->
    (res_q.match_index == '0) && (res_q.match_time == '0))
    else $error("failed item carries point data");

endmodule

### rtl/trajectory_nearest_point_query.sv
// Top level of the trajectory nearest-point query block: configuration
// registers, result output register and the point store with its sequencer.
// Depends on trajnq_pkg, trajnq_mem and trajnq_engine.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   in_item_i (item_in_t)
//   out      output     out_valid_o/out_ready_i out_item_o (item_out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Clear, append, unused opcodes and queries on an empty table go straight
// from the accepted item to the result. A query reads one point per cycle
// through the single read port of the point store, then the pipeline drains
// and the chosen point is fetched. Reset empties the table and clears the
// configuration registers. A new item is taken while a result waits in the
// output register; the sequencer stalls only when its own result finds that
// register still full.
module trajectory_nearest_point_query #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  trajnq_pkg::item_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output trajnq_pkg::item_out_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [trajnq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trajnq_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW  = $clog2(MAX_POINTS);
  localparam int unsigned CountW = $clog2(MAX_POINTS + 1);

  trajnq_pkg::cfg_t      cfg_q;
  logic                  out_valid_q;
  trajnq_pkg::item_out_t out_item_q;
  logic                  res_valid, res_ready;
  trajnq_pkg::item_out_t res_item;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  trajnq_pkg::point_t    mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        trajnq_pkg::CFG_HEADER_TIME:  cfg_q.header_time  <= cfg_data_i;
        trajnq_pkg::CFG_FORWARD_ONLY: cfg_q.forward_only <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  trajnq_mem #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  trajnq_engine #(
    .MaxPoints (MAX_POINTS),
    .AddrW     (AddrW),
    .CountW    (CountW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
